// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int BDQ_DEPTH   = 16;
   localparam int BDQ_VALUE_W = 32;
   localparam int BDQ_OP_W    = 3;
   localparam int BDQ_POS_W   = 4;
   localparam int BDQ_OCC_W   = 5;

   typedef enum logic [BDQ_OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_REM_BACK  = 3'd3,
      OP_SEARCH    = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // status sits in the lowest bits
   typedef struct packed {
      logic [BDQ_OCC_W-1:0] occupancy;
      logic [BDQ_POS_W-1:0] found_position;
      status_type           status;
   } rsp_type;

endpackage

// ===== rtl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Double-ended queue of signed 32-bit values with a linear search.
// ----------------------------------------------------------------------------
// Values sit in a ring of DEPTH entries in one synchronous memory. Inserts and
// removals at either end are taken at one per cycle while the result register
// is free; an insert into a full queue is refused with status full, a removal
// or search on an empty one gives status empty. A search reads the held
// entries from the front, one per cycle through the single memory read port,
// and stops at the first match or after the last held entry. One item is in
// work at a time; the result register lets the next transaction in while a
// result waits to be taken.
module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int DEPTH = BDQ_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [5:2] found_position,
                                    // [10:6] occupancy, [15:11] zero
);

   localparam int AW = $clog2(DEPTH);

   rsp_type                rsp_data;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [BDQ_VALUE_W-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [BDQ_VALUE_W-1:0] mem_rd_data;

   bdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser),
      .req_value   (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bdq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {5'b0, rsp_data};

endmodule

// ===== rtl/bdq_mem.sv =====
// ----------------------------------------------------------------------------
// bdq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_mem
   import bdq_pkg::*;
#(
   parameter int DEPTH = BDQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BDQ_VALUE_W-1:0]   wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BDQ_VALUE_W-1:0]   rd_data
);

   logic [BDQ_VALUE_W-1:0] store_ff [DEPTH];
   logic [BDQ_VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front index, count, operation decode, search sequencer and result register.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int DEPTH = BDQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BDQ_OP_W-1:0]      req_opcode,
   input  logic [BDQ_VALUE_W-1:0]   req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   output logic                     mem_wr_en,
   output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
   output logic [BDQ_VALUE_W-1:0]   mem_wr_data,
   output logic                     mem_rd_en,
   output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
   input  logic [BDQ_VALUE_W-1:0]   mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_DONE   = 3'b100
   } state_type;

   state_type            state_ff,   state_in;
   logic [AW-1:0]        front_ff,   front_in;
   logic [CW-1:0]        count_ff,   count_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_ff,     rsp_in;
   rsp_type              res_ff,     res_in;
   logic [BDQ_VALUE_W-1:0] key_ff,   key_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;

   logic                 out_free;
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 load;
   status_type           st;
   logic [AW:0]          back_sum;
   logic [AW-1:0]        back_addr;
   logic                 last_cmp;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      ring_next = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
      ring_prev = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
   endfunction

   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign back_sum  = (AW+1)'(front_ff) + (AW+1)'(count_ff);
   assign back_addr = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                   : AW'(back_sum);
   assign last_cmp  = ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      res_in      = res_ff;
      key_in      = key_ff;
      cmp_idx_in  = cmp_idx_ff;
      rd_addr_in  = rd_addr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = front_ff;
      mem_wr_data = req_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_addr_ff;
      load        = 1'b0;
      st          = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load = 1'b1;
               unique case (req_opcode)
                  OP_INS_FRONT: begin
                     if (full) begin
                        st = ST_FULL;
                     end else begin
                        front_in    = ring_prev(front_ff);
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = ring_prev(front_ff);
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  OP_INS_BACK: begin
                     if (full) begin
                        st = ST_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = back_addr;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  OP_REM_FRONT: begin
                     if (empty) begin
                        st = ST_EMPTY;
                     end else begin
                        front_in = ring_next(front_ff);
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_REM_BACK: begin
                     if (empty) begin
                        st = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (empty) begin
                        st = ST_EMPTY;
                     end else begin
                        load        = 1'b0;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = front_ff;
                        rd_addr_in  = ring_next(front_ff);
                        cmp_idx_in  = '0;
                        key_in      = req_value;
                        state_in    = S_SEARCH;
                     end
                  end
                  default: begin
                     st = ST_OK;
                  end
               endcase
               if (load) begin
                  res_in.status         = st;
                  res_in.found_position = '0;
                  res_in.occupancy      = BDQ_OCC_W'(count_in);
                  // park the result while the output register is still taken
                  if (out_free) begin
                     rsp_vld_in = 1'b1;
                     rsp_in     = res_in;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_SEARCH: begin
            // compare the entry read last cycle, issue the next read meanwhile
            if (mem_rd_data == key_ff) begin
               res_in.status         = ST_OK;
               res_in.found_position = BDQ_POS_W'(cmp_idx_ff);
               res_in.occupancy      = BDQ_OCC_W'(count_ff);
               state_in              = S_DONE;
            end else if (last_cmp) begin
               res_in.status         = ST_NOTFOUND;
               res_in.found_position = '0;
               res_in.occupancy      = BDQ_OCC_W'(count_ff);
               state_in              = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_addr_ff;
               rd_addr_in  = ring_next(rd_addr_ff);
               cmp_idx_in  = cmp_idx_ff + AW'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = res_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         front_ff   <= '0;
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      res_ff     <= res_in;
      key_ff     <= key_in;
      cmp_idx_ff <= cmp_idx_in;
      rd_addr_ff <= rd_addr_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/bounded_deque_with_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_tb
// Self-checking bench for the bounded deque with linear search.
// ----------------------------------------------------------------------------
// A directed opening covers empty removals and searches, extreme values, hits
// at the first and last positions, refused inserts when full and the unused
// opcodes. Random phases then alternate between filling and draining the
// deque, with search keys drawn often from recently stored values. Each
// transaction is applied to a mirror of the ring and the predicted response
// is compared field by field. Both sides idle at random, with a calm stretch
// and two long receiver hold-offs that back the block up.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_tb;
   import bdq_pkg::*;

   localparam int OPCODE_MAX   = (1 << BDQ_OP_W) - 1;
   localparam int IDLE_PCT     = 32;
   localparam int CALM_FROM    = 900;
   localparam int CALM_TO      = 1500;
   localparam int HOLD_A       = 400;
   localparam int HOLD_B       = 2000;
   localparam int HOLD_LEN     = 150;
   localparam int RANDOM_ITEMS = 775;
   localparam int PHASE_LEN    = 48;
   localparam int DRAIN_CYCLES = 2 * BDQ_DEPTH + 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [BDQ_OP_W-1:0]    opcode;
      logic [BDQ_VALUE_W-1:0] value;
   } deque_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [2:0]  req_tuser = '0;   // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [1:0] status, [5:2] found_position,
                                  // [10:6] occupancy, [15:11] zero

   deque_item_type pending_items[$];
   rsp_type   expected_rsp[$];
   logic [BDQ_VALUE_W-1:0] recent_values[$];

   logic [BDQ_VALUE_W-1:0] mirror_store [BDQ_DEPTH];
   int mirror_head  = 0;
   int mirror_count = 0;

   int cycle_count    = 0;
   int hold_left      = 0;
   int mismatch_count = 0;
   int checked_count  = 0;
   int status_tally [4] = '{0, 0, 0, 0};
   logic calm_stretch;

   assign calm_stretch = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   bounded_deque_with_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // mirror of the ring; returns the response the block should give
   function automatic rsp_type apply_deque_op(input logic [BDQ_OP_W-1:0] opcode,
                                              input logic [BDQ_VALUE_W-1:0] value);
      rsp_type r;
      int      i;
      logic    hit;
      r.status         = ST_OK;
      r.found_position = '0;
      hit              = 1'b0;
      case (opcode)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (mirror_count >= BDQ_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (opcode == OP_INS_FRONT) begin
                  mirror_head = (mirror_head + BDQ_DEPTH - 1) % BDQ_DEPTH;
                  mirror_store[mirror_head] = value;
               end else begin
                  mirror_store[(mirror_head + mirror_count) % BDQ_DEPTH] = value;
               end
               mirror_count++;
            end
         end
         OP_REM_FRONT, OP_REM_BACK: begin
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (opcode == OP_REM_FRONT)
                  mirror_head = (mirror_head + 1) % BDQ_DEPTH;
               mirror_count--;
            end
         end
         OP_SEARCH: begin
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_NOTFOUND;
               for (i = 0; i < mirror_count && !hit; i++) begin
                  if (mirror_store[(mirror_head + i) % BDQ_DEPTH] == value) begin
                     hit              = 1'b1;
                     r.status         = ST_OK;
                     r.found_position = i[BDQ_POS_W-1:0];
                  end
               end
            end
         end
         default: ;
      endcase
      r.occupancy = mirror_count[BDQ_OCC_W-1:0];
      return r;
   endfunction

   task automatic queue_item(input logic [BDQ_OP_W-1:0] opcode,
                             input logic [BDQ_VALUE_W-1:0] value);
      deque_item_type it;
      it.opcode = opcode;
      it.value  = value;
      pending_items.push_back(it);
      if (opcode == OP_INS_FRONT || opcode == OP_INS_BACK) begin
         recent_values.push_back(value);
         if (recent_values.size() > 24)
            void'(recent_values.pop_front());
      end
   endtask

   // small values collide often, recent ones give search hits
   function automatic logic [BDQ_VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35)
         return 32'(int'($urandom_range(7)) - 4);
      else if (roll < 65 && recent_values.size() != 0)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      else
         return $urandom();
   endfunction

   task automatic build_stimulus();
      int          n;
      int          op;
      int unsigned roll;
      logic        filling;
      queue_item(OP_SEARCH, '0);
      queue_item(OP_REM_FRONT, '1);
      queue_item(OP_REM_BACK, '0);
      queue_item(OP_INS_BACK, 32'h7FFF_FFFF);
      queue_item(OP_INS_FRONT, 32'h8000_0000);
      queue_item(OP_INS_BACK, 32'h0000_0000);
      queue_item(OP_INS_BACK, 32'hFFFF_FFFF);
      queue_item(OP_SEARCH, 32'h8000_0000);
      for (op = OP_SEARCH + 1; op <= OPCODE_MAX; op++)
         queue_item(op[BDQ_OP_W-1:0], $urandom());
      for (n = 0; n < BDQ_DEPTH - 5; n++)
         queue_item(($urandom_range(1) != 0) ? OP_INS_BACK : OP_INS_FRONT, $urandom());
      queue_item(OP_INS_BACK, 32'h5A5A_0F0F);
      queue_item(OP_INS_FRONT, 32'h1111_2222);
      queue_item(OP_INS_BACK, 32'h3333_4444);
      queue_item(OP_SEARCH, 32'h5A5A_0F0F);
      queue_item(OP_SEARCH, 32'h1357_9BDF);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         filling = ((n / PHASE_LEN) % 2) == 0;
         roll    = $urandom_range(99);
         if (roll < 5)
            op = $urandom_range(OPCODE_MAX, OP_SEARCH + 1);
         else if (roll < 30)
            op = OP_SEARCH;
         else if (roll < (filling ? 80 : 45))
            op = ($urandom_range(1) != 0) ? OP_INS_BACK : OP_INS_FRONT;
         else
            op = ($urandom_range(1) != 0) ? OP_REM_BACK : OP_REM_FRONT;
         queue_item(op[BDQ_OP_W-1:0], pick_value());
      end
   endtask

   task automatic check_response(input logic [15:0] word);
      rsp_type got;
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         $display("%0t: unexpected response, got %h", $time, word);
         mismatch_count++;
      end else begin
         want = expected_rsp.pop_front();
         got  = rsp_type'(word[10:0]);
         checked_count++;
         status_tally[want.status]++;
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            mismatch_count++;
         end
         if (got.found_position !== want.found_position) begin
            $display("%0t: found_position mismatch, expected %0d, got %0d",
                     $time, want.found_position, got.found_position);
            mismatch_count++;
         end
         if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch, expected %0d, got %0d",
                     $time, want.occupancy, got.occupancy);
            mismatch_count++;
         end
         if (word[15:11] !== 5'd0) begin
            $display("%0t: padding mismatch, expected 0, got %h", $time, word[15:11]);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles", $time, cycle_count);
         $display("bounded_deque_with_search_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycle_count == HOLD_A || cycle_count == HOLD_B) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : drive_req
      deque_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp.push_back(apply_deque_op(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 &&
                (calm_stretch || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tuser  <= nxt.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response(rsp_tdata);
         rsp_tready <= (hold_left == 0) &&
                       (calm_stretch || $urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // sample between edges so the driver's updates have settled
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d transactions checked in %0d cycles", checked_count, cycle_count);
      $display("statuses seen: ok %0d, empty %0d, full %0d, not found %0d",
               status_tally[ST_OK], status_tally[ST_EMPTY],
               status_tally[ST_FULL], status_tally[ST_NOTFOUND]);
      if (mismatch_count == 0)
         $display("bounded_deque_with_search_tb OK");
      else
         $display("bounded_deque_with_search_tb NOT OK");
      $finish;
   end

endmodule
